[rtl/bcs_pkg.sv]
// bcs_pkg: shared types, codes and helper functions of the byte-code step core
`default_nettype none
package bcs_pkg;

  localparam int BCS_MEM_SIZE = 65536;
  localparam int IN_DATA_W    = 32;
  localparam int IN_USER_W    = 2;
  localparam int OUT_DATA_W   = 112;

  localparam logic [15:0] PC_START      = 16'h0100;
  localparam logic [15:0] SP_INIT       = 16'hFFFE;
  localparam logic [15:0] MAX_STEPS_RST = 16'd5000;

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_EXEC  = 2'd2;

  localparam logic [2:0] CAUSE_NONE  = 3'd0;
  localparam logic [2:0] CAUSE_HALT  = 3'd1;
  localparam logic [2:0] CAUSE_DIV0  = 3'd2;
  localparam logic [2:0] CAUSE_BADOP = 3'd3;
  localparam logic [2:0] CAUSE_LIMIT = 3'd4;

  localparam logic [7:0] OPC_LDI  = 8'h01;
  localparam logic [7:0] OPC_MOV  = 8'h02;
  localparam logic [7:0] OPC_ADD  = 8'h03;
  localparam logic [7:0] OPC_SUB  = 8'h04;
  localparam logic [7:0] OPC_LD   = 8'h05;
  localparam logic [7:0] OPC_ST   = 8'h06;
  localparam logic [7:0] OPC_CMP  = 8'h07;
  localparam logic [7:0] OPC_INT  = 8'h10;
  localparam logic [7:0] OPC_LEA  = 8'h15;
  localparam logic [7:0] OPC_PRS  = 8'h20;
  localparam logic [7:0] OPC_PUSH = 8'h30;
  localparam logic [7:0] OPC_POP  = 8'h31;
  localparam logic [7:0] OPC_CALL = 8'h32;
  localparam logic [7:0] OPC_RET  = 8'h33;
  localparam logic [7:0] OPC_JMP  = 8'h40;
  localparam logic [7:0] OPC_JZ   = 8'h41;
  localparam logic [7:0] OPC_JNZ  = 8'h42;
  localparam logic [7:0] OPC_MUL  = 8'h50;
  localparam logic [7:0] OPC_DIV  = 8'h51;

  localparam logic [7:0] INT_SYS  = 8'h21;
  localparam logic [7:0] AH_HALT  = 8'h4C;
  localparam logic [7:0] AH_GETC  = 8'h01;
  localparam logic [7:0] AH_PUTC  = 8'h02;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DECODE, ST_FETCH, ST_FCAP, ST_EXEC,
    ST_MRD, ST_MCAP, ST_MWR, ST_DIV, ST_FINISH, ST_DONE
  } bcs_state_t;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_CLEAR, CMD_LATCH, CMD_DECODE, CMD_FETCH, CMD_FCAP, CMD_EXEC,
    CMD_MRD, CMD_MCAP, CMD_MWR, CMD_DIV, CMD_FINISH, CMD_OUT
  } cmd_code_t;

  typedef struct packed {
    cmd_code_t   code;
    logic [1:0]  fidx;
    logic        acnt;
    logic        last;
    logic [15:0] clr_addr;
  } bcs_cmd_t;

  typedef struct packed {
    logic       go_exec;
    logic [2:0] ilen;
    logic [1:0] mem_n;
    logic       mem_wr;
    logic       div_go;
  } bcs_stat_t;

  function automatic logic [2:0] inst_len(input logic [7:0] op);
    case (op)
      OPC_INT:                   return 3'd2;
      OPC_MOV, OPC_PRS,
      OPC_MUL, OPC_DIV:          return 3'd3;
      OPC_LDI, OPC_ADD, OPC_SUB, OPC_CMP, OPC_LD, OPC_ST, OPC_PUSH, OPC_POP,
      OPC_CALL, OPC_JMP, OPC_JZ, OPC_JNZ, OPC_LEA: return 3'd4;
      default:                   return 3'd1;
    endcase
  endfunction

  function automatic logic [7:0] get8(input logic [3:0][15:0] r, input logic [7:0] id);
    logic [15:0] w;
    w = r[id[2:1]];
    if (id > 8'd7) return 8'h00;
    return id[0] ? w[15:8] : w[7:0];
  endfunction

  function automatic logic [3:0][15:0] set8(input logic [3:0][15:0] r,
                                            input logic [7:0] id, input logic [7:0] v);
    logic [3:0][15:0] n;
    n = r;
    if (id <= 8'd7) begin
      if (id[0]) begin
        n[id[2:1]][15:8] = v;
      end else begin
        n[id[2:1]][7:0] = v;
      end
    end
    return n;
  endfunction

  // address reduction for memory sizes of 1024 and up
  function automatic logic [15:0] mem_wrap(input logic [15:0] a, input logic [16:0] msz);
    logic [22:0] x;
    x = {7'd0, a};
    for (int i = 5; i >= 0; i--) begin
      if (x >= ({6'd0, msz} << i)) x = x - ({6'd0, msz} << i);
    end
    return x[15:0];
  endfunction

endpackage
`default_nettype wire

[rtl/bcs_ram.sv]
// bcs_ram: generic single-port ram with registered read
`default_nettype none
module bcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] addr,
  input  wire  [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

[rtl/bcs_ctrl.sv]
// bcs_ctrl: sequencing state machine of the step core
`default_nettype none
module bcs_ctrl import bcs_pkg::*; #(
  parameter int MEM_SIZE = BCS_MEM_SIZE
) (
  input  wire       clk,
  input  wire       rst_n,
  input  wire       in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  wire       out_tready,
  input  bcs_stat_t stat,
  output bcs_cmd_t  cmd
);
  localparam int AW = $clog2(MEM_SIZE);

  bcs_state_t   state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [1:0]   fidx_r, fidx_nxt;
  logic         acnt_r, acnt_nxt;
  logic [3:0]   dcnt_r, dcnt_nxt;
  logic         ov_r, ov_nxt;
  logic         can_out;

  assign can_out    = !ov_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      fidx_r  <= '0;
      acnt_r  <= 1'b0;
      dcnt_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      fidx_r  <= fidx_nxt;
      acnt_r  <= acnt_nxt;
      dcnt_r  <= dcnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    fidx_nxt  = fidx_r;
    acnt_nxt  = acnt_r;
    dcnt_nxt  = dcnt_r;
    ov_nxt    = ov_r && !out_tready;
    case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(MEM_SIZE - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        fidx_nxt  = '0;
        state_nxt = stat.go_exec ? ST_FETCH : ST_DONE;
      end
      ST_FETCH: state_nxt = ST_FCAP;
      ST_FCAP: begin
        if ({1'b0, fidx_r} + 3'd1 == stat.ilen) begin
          state_nxt = ST_EXEC;
        end else begin
          fidx_nxt  = fidx_r + 2'd1;
          state_nxt = ST_FETCH;
        end
      end
      ST_EXEC: begin
        acnt_nxt = 1'b0;
        dcnt_nxt = '0;
        if (stat.mem_n != 2'd0) begin
          state_nxt = stat.mem_wr ? ST_MWR : ST_MRD;
        end else if (stat.div_go) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_MRD: state_nxt = ST_MCAP;
      ST_MCAP: begin
        if ({1'b0, acnt_r} == stat.mem_n - 2'd1) begin
          state_nxt = ST_FINISH;
        end else begin
          acnt_nxt  = 1'b1;
          state_nxt = ST_MRD;
        end
      end
      ST_MWR: begin
        if ({1'b0, acnt_r} == stat.mem_n - 2'd1) begin
          state_nxt = ST_FINISH;
        end else begin
          acnt_nxt = 1'b1;
        end
      end
      ST_DIV: begin
        dcnt_nxt = dcnt_r + 4'd1;
        if (dcnt_r == 4'd15) state_nxt = ST_FINISH;
      end
      ST_FINISH: state_nxt = ST_DONE;
      ST_DONE: begin
        if (can_out) begin
          ov_nxt    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.code     = CMD_NONE;
    cmd.fidx     = fidx_r;
    cmd.acnt     = acnt_r;
    cmd.last     = (dcnt_r == 4'd15);
    cmd.clr_addr = 16'(clr_r);
    case (state_r)
      ST_CLEAR:  cmd.code = CMD_CLEAR;
      ST_IDLE:   cmd.code = in_tvalid ? CMD_LATCH : CMD_NONE;
      ST_DECODE: cmd.code = CMD_DECODE;
      ST_FETCH:  cmd.code = CMD_FETCH;
      ST_FCAP:   cmd.code = CMD_FCAP;
      ST_EXEC:   cmd.code = CMD_EXEC;
      ST_MRD:    cmd.code = CMD_MRD;
      ST_MCAP:   cmd.code = CMD_MCAP;
      ST_MWR:    cmd.code = CMD_MWR;
      ST_DIV:    cmd.code = CMD_DIV;
      ST_FINISH: cmd.code = CMD_FINISH;
      ST_DONE:   cmd.code = can_out ? CMD_OUT : CMD_NONE;
      default:   cmd.code = CMD_NONE;
    endcase
  end
endmodule
`default_nettype wire

[rtl/bcs_dpath.sv]
// bcs_dpath: registers, memory, alu, divider and result register of the step core
`default_nettype none
module bcs_dpath import bcs_pkg::*; #(
  parameter int MEM_SIZE = BCS_MEM_SIZE
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  bcs_cmd_t               cmd,
  output bcs_stat_t              stat,
  input  wire  [IN_USER_W-1:0]   in_tuser,
  input  wire  [IN_DATA_W-1:0]   in_tdata,
  input  wire                    cfg_wr_en,
  input  wire  [15:0]            cfg_wr_data,
  output logic [OUT_DATA_W-1:0]  out_tdata
);
  localparam int AW = $clog2(MEM_SIZE);
  localparam logic [16:0] MSZ = 17'(MEM_SIZE);

  logic [3:0][15:0] wreg_r, wreg_nxt;
  logic [15:0] pc_r, pc_nxt, sp_r, sp_nxt, steps_r, steps_nxt, maxs_r;
  logic        zf_r, zf_nxt, run_r, run_nxt;
  logic [2:0]  cause_r, cause_nxt;
  logic        cv_r, cv_nxt;
  logic [7:0]  co_r, co_nxt;
  logic [3:0][7:0] buf_r, buf_nxt;
  logic [1:0]  req_r;
  logic [15:0] laddr_r;
  logic [7:0]  ldata_r, cin_r;
  logic [15:0] tmp_r, tmp_nxt, dq_r, dq_nxt;
  logic [7:0]  dr_r, dr_nxt, dv_r, dv_nxt;
  logic [OUT_DATA_W-1:0] out_r;

  logic [7:0]  b0, b1, b2, b3, srcv, resb;
  logic [15:0] imm, maddr, prod, pushw, popw, steps_inc;
  logic [15:0] pc_wa, ma_wa;
  logic [8:0]  dsh;
  logic        dge;
  logic [7:0]  dsub;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wd, ram_rd;

  assign b0  = buf_r[0];
  assign b1  = buf_r[1];
  assign b2  = buf_r[2];
  assign b3  = buf_r[3];
  assign imm = {b3, b2};
  assign popw = {ram_rd, tmp_r[7:0]};
  assign steps_inc = steps_r + 16'd1;
  assign prod = 16'(get8(wreg_r, 8'd0)) * 16'(get8(wreg_r, b1));
  assign dsh  = {dr_r, dq_r[15]};
  assign dge  = dsh >= {1'b0, dv_r};
  assign dsub = 8'(dsh - {1'b0, dv_r});

  always_comb begin
    case (b0)
      OPC_LD:  maddr = {b3, b2};
      OPC_ST:  maddr = {b2, b1};
      default: maddr = sp_r + {15'd0, cmd.acnt};
    endcase
  end

  assign pc_wa = mem_wrap(pc_r, MSZ);
  assign ma_wa = mem_wrap(maddr, MSZ);

  bcs_ram #(.WIDTH(8), .DEPTH(MEM_SIZE)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wd),
    .rdata (ram_rd)
  );

  always_comb begin
    ram_we   = 1'b0;
    ram_wd   = 8'h00;
    ram_addr = pc_wa[AW-1:0];
    case (cmd.code)
      CMD_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = cmd.clr_addr[AW-1:0];
      end
      CMD_DECODE: begin
        ram_addr = laddr_r[AW-1:0];
        ram_wd   = ldata_r;
        ram_we   = (req_r == REQ_LOAD) && ({1'b0, laddr_r} < MSZ);
      end
      CMD_MRD: ram_addr = ma_wa[AW-1:0];
      CMD_MWR: begin
        ram_addr = ma_wa[AW-1:0];
        ram_we   = 1'b1;
        if (b0 == OPC_ST) begin
          ram_wd = (b3 <= 8'd3) ? get8(wreg_r, b3) : 8'h00;
        end else begin
          ram_wd = cmd.acnt ? tmp_r[15:8] : tmp_r[7:0];
        end
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_comb begin
    stat.go_exec = (req_r == REQ_EXEC) && run_r && (steps_r < maxs_r);
    stat.ilen    = inst_len((cmd.fidx == 2'd0) ? ram_rd : b0);
    stat.mem_wr  = 1'b0;
    stat.div_go  = (b0 == OPC_DIV) && (get8(wreg_r, b1) != 8'h00);
    case (b0)
      OPC_LD:  stat.mem_n = 2'd1;
      OPC_ST:  begin
        stat.mem_n  = 2'd1;
        stat.mem_wr = 1'b1;
      end
      OPC_POP, OPC_RET: stat.mem_n = 2'd2;
      OPC_PUSH, OPC_CALL: begin
        stat.mem_n  = 2'd2;
        stat.mem_wr = 1'b1;
      end
      default: stat.mem_n = 2'd0;
    endcase
  end

  always_comb begin
    wreg_nxt  = wreg_r;
    pc_nxt    = pc_r;
    sp_nxt    = sp_r;
    steps_nxt = steps_r;
    zf_nxt    = zf_r;
    run_nxt   = run_r;
    cause_nxt = cause_r;
    cv_nxt    = cv_r;
    co_nxt    = co_r;
    buf_nxt   = buf_r;
    tmp_nxt   = tmp_r;
    dq_nxt    = dq_r;
    dr_nxt    = dr_r;
    dv_nxt    = dv_r;
    srcv      = b3;
    resb      = 8'h00;
    pushw     = imm;
    case (cmd.code)
      CMD_LATCH: begin
        cause_nxt = CAUSE_NONE;
        cv_nxt    = 1'b0;
        co_nxt    = 8'h00;
      end
      CMD_DECODE: begin
        case (req_r)
          REQ_LOAD: pc_nxt = PC_START;
          REQ_START: begin
            run_nxt   = 1'b1;
            steps_nxt = '0;
            if (sp_r == 16'd0) sp_nxt = SP_INIT;
          end
          REQ_EXEC: begin
            if (run_r && (steps_r >= maxs_r)) begin
              run_nxt   = 1'b0;
              cause_nxt = CAUSE_LIMIT;
            end
          end
          default: pc_nxt = pc_r;
        endcase
      end
      CMD_FCAP: begin
        buf_nxt[cmd.fidx] = ram_rd;
        pc_nxt = pc_r + 16'd1;
      end
      CMD_EXEC: begin
        case (b0)
          OPC_LDI: wreg_nxt = set8(wreg_r, b1, b2);
          OPC_MOV: wreg_nxt = set8(wreg_r, b1, get8(wreg_r, b2));
          OPC_ADD, OPC_SUB: begin
            if (b2 == 8'd1 && b3 <= 8'd7) srcv = get8(wreg_r, b3);
            resb = (b0 == OPC_SUB) ? get8(wreg_r, b1) - srcv : get8(wreg_r, b1) + srcv;
            if (b1 <= 8'd7) begin
              wreg_nxt = set8(wreg_r, b1, resb);
              zf_nxt   = (resb == 8'h00);
            end
          end
          OPC_CMP: begin
            if (b2 == 8'd1 && b3 <= 8'd3) srcv = get8(wreg_r, b3);
            zf_nxt = (((b1 <= 8'd3) ? get8(wreg_r, b1) : 8'h00) == srcv);
          end
          OPC_LD, OPC_ST, OPC_PRS, OPC_POP, OPC_RET: zf_nxt = zf_r;
          OPC_INT: begin
            if (b1 == INT_SYS) begin
              if (wreg_r[0][15:8] == AH_HALT) begin
                run_nxt   = 1'b0;
                cause_nxt = CAUSE_HALT;
              end else if (wreg_r[0][15:8] == AH_GETC) begin
                wreg_nxt[0][7:0] = cin_r;
              end else if (wreg_r[0][15:8] == AH_PUTC) begin
                cv_nxt = 1'b1;
                co_nxt = wreg_r[3][7:0];
              end
            end
          end
          OPC_PUSH: begin
            if (b1 == 8'd1 && imm <= 16'd3) pushw = wreg_r[imm[1:0]];
            tmp_nxt = pushw;
            sp_nxt  = sp_r - 16'd2;
          end
          OPC_CALL: begin
            tmp_nxt = pc_r;
            pc_nxt  = imm;
            sp_nxt  = sp_r - 16'd2;
          end
          OPC_JMP: pc_nxt = imm;
          OPC_JZ:  if (zf_r) pc_nxt = imm;
          OPC_JNZ: if (!zf_r) pc_nxt = imm;
          OPC_MUL: begin
            wreg_nxt[0] = prod;
            zf_nxt      = (prod == 16'd0);
          end
          OPC_DIV: begin
            if (get8(wreg_r, b1) == 8'h00) begin
              run_nxt   = 1'b0;
              cause_nxt = CAUSE_DIV0;
            end
            dq_nxt = wreg_r[0];
            dr_nxt = 8'h00;
            dv_nxt = get8(wreg_r, b1);
          end
          OPC_LEA: begin
            if (b1 == 8'd0 || b1 == 8'd2 || b1 == 8'd4 || b1 == 8'd6) begin
              wreg_nxt[b1[2:1]] = imm;
            end
          end
          default: begin
            run_nxt   = 1'b0;
            cause_nxt = CAUSE_BADOP;
          end
        endcase
      end
      CMD_MCAP: begin
        if (b0 == OPC_LD) begin
          if (b1 <= 8'd3) wreg_nxt = set8(wreg_r, b1, ram_rd);
        end else if (!cmd.acnt) begin
          tmp_nxt[7:0] = ram_rd;
        end else begin
          sp_nxt = sp_r + 16'd2;
          if (b0 == OPC_RET) begin
            pc_nxt = popw;
          end else if (b2 <= 8'd3) begin
            wreg_nxt[b2[1:0]] = popw;
          end
        end
      end
      CMD_DIV: begin
        dr_nxt = dge ? dsub : dsh[7:0];
        dq_nxt = {dq_r[14:0], dge};
        if (cmd.last) wreg_nxt[0] = {dr_nxt, dq_nxt[7:0]};
      end
      CMD_FINISH: begin
        steps_nxt = steps_inc;
        if (run_r && steps_inc >= maxs_r) begin
          run_nxt   = 1'b0;
          cause_nxt = CAUSE_LIMIT;
        end
      end
      default: pc_nxt = pc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wreg_r  <= '0;
      pc_r    <= '0;
      sp_r    <= '0;
      steps_r <= '0;
      zf_r    <= 1'b0;
      run_r   <= 1'b0;
      cause_r <= CAUSE_NONE;
      cv_r    <= 1'b0;
      co_r    <= 8'h00;
      maxs_r  <= MAX_STEPS_RST;
    end else begin
      wreg_r  <= wreg_nxt;
      pc_r    <= pc_nxt;
      sp_r    <= sp_nxt;
      steps_r <= steps_nxt;
      zf_r    <= zf_nxt;
      run_r   <= run_nxt;
      cause_r <= cause_nxt;
      cv_r    <= cv_nxt;
      co_r    <= co_nxt;
      if (cfg_wr_en) maxs_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
    tmp_r <= tmp_nxt;
    dq_r  <= dq_nxt;
    dr_r  <= dr_nxt;
    dv_r  <= dv_nxt;
    if (cmd.code == CMD_LATCH) begin
      req_r   <= in_tuser;
      laddr_r <= in_tdata[15:0];
      ldata_r <= in_tdata[23:16];
      cin_r   <= in_tdata[31:24];
    end
    if (cmd.code == CMD_OUT) begin
      out_r <= {2'b00, cause_r, co_r, cv_r, run_r, zf_r, sp_r,
                wreg_r[3], wreg_r[2], wreg_r[1], wreg_r[0], pc_r};
    end
  end

  assign out_tdata = out_r;
endmodule
`default_nettype wire

[rtl/byte_code_cpu_step_core.sv]
// byte_code_cpu_step_core: top level of the byte-code processor step core
// load, start and idle words pass from accept through the decode and done states
// execute word: decode, fetch and capture per instruction byte (1..4), execute,
//   read/capture per byte read, write per byte written (0..2), bit-serial divide
// one word in flight; the next word can be taken in the same cycle as the result is presented
// reset: memory clearing pass over every address, in_tready low until it ends
`default_nettype none
module byte_code_cpu_step_core import bcs_pkg::*; #(
  parameter int MEM_SIZE = BCS_MEM_SIZE
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_tvalid,
  output logic                  in_tready,
  // load_address, load_data, console_char
  input  wire  [IN_DATA_W-1:0]  in_tdata,
  // req_type
  input  wire  [IN_USER_W-1:0]  in_tuser,
  output logic                  out_tvalid,
  input  wire                   out_tready,
  // pc_now, acc_now, base_now, count_now, data_now, stack_now, zero_now,
  // is_running, char_valid, char_out, stop_cause
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  wire                   cfg_wr_en,
  input  wire  [15:0]           cfg_wr_data
);
  bcs_cmd_t  cmd;
  bcs_stat_t stat;

  bcs_ctrl #(.MEM_SIZE(MEM_SIZE)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  bcs_dpath #(.MEM_SIZE(MEM_SIZE)) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tdata   (out_tdata)
  );
endmodule
`default_nettype wire

[rtl/bcs_checker.sv]
// bcs_checker: port-level assertions for the step core and their bind
`default_nettype none
module bcs_checker import bcs_pkg::*; (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  in_tvalid,
  input wire                  in_tready,
  input wire                  out_tvalid,
  input wire                  out_tready,
  input wire [OUT_DATA_W-1:0] out_tdata
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word accepted while busy");

  a_stop_clears_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[109:107] != CAUSE_NONE |-> !out_tdata[97])
    else $error("stop reported while still running");

  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[98] |-> out_tdata[106:99] == 8'h00)
    else $error("char_out set without char_valid");

  a_cause_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[109:107] <= CAUSE_LIMIT)
    else $error("stop cause out of range");
endmodule

bind byte_code_cpu_step_core bcs_checker u_bcs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
